@@ design/assert_macros.svh @@
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define DTB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define DTB_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/dtb_pkg.sv @@
// Package: constants and character codes for the decimal text to BCD real block.
`default_nettype none
package dtb_pkg;

  localparam int DIGITS = 14;

  localparam int EXP_MAG_W = 14;
  localparam logic [EXP_MAG_W-1:0] EXP_MAG_MAX = 14'd16383;
  localparam logic [EXP_MAG_W-1:0] EXP_WARN_LIMIT = 14'd99;

  localparam logic [7:0] EXP_BIAS     = 8'h80;
  localparam logic [7:0] SIGN_FLAG    = 8'h80;
  localparam logic [7:0] COMPLEX_FLAG = 8'h0C;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_E_UP  = 8'h45;
  localparam logic [7:0] CH_E_LO  = 8'h65;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [3:0] ROUND_HALF = 4'd5;

endpackage
`default_nettype wire

@@ design/dtb_if.sv @@
// Interfaces: character input channel and result output channel.
`default_nettype none
interface dtb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;
  logic       complex_part;

  modport source (output valid, char_code, is_last, complex_part, input ready);
  modport sink   (input valid, char_code, is_last, complex_part, output ready);
endinterface

interface dtb_out_if #(parameter int DIGITS = dtb_pkg::DIGITS);
  logic                  valid;
  logic                  ready;
  logic [7:0]            flag_byte;
  logic [7:0]            exponent_byte;
  logic [4*DIGITS-1:0]   mantissa_bcd;
  logic                  exponent_warning;

  modport source (output valid, flag_byte, exponent_byte, mantissa_bcd, exponent_warning,
                  input ready);
  modport sink   (input valid, flag_byte, exponent_byte, mantissa_bcd, exponent_warning,
                  output ready);
endinterface
`default_nettype wire

@@ design/dtb_bcd_inc.sv @@
// BCD incrementer: adds one to a packed BCD mantissa with full digit carry.
`default_nettype none
module dtb_bcd_inc #(
  parameter int DIGITS = dtb_pkg::DIGITS
) (
  input  wire logic [4*DIGITS-1:0] mant,
  output logic      [4*DIGITS-1:0] mant_inc,
  output logic                     overflow
);

  logic [DIGITS:0] carry;

  always_comb begin
    carry[0] = 1'b1;
    for (int k = 0; k < DIGITS; k++) begin
      carry[k+1] = carry[k] && (mant[4*k +: 4] >= 4'd9);
    end
  end

  always_comb begin
    mant_inc = mant;
    for (int k = 0; k < DIGITS; k++) begin
      if (carry[k]) begin
        mant_inc[4*k +: 4] = (mant[4*k +: 4] >= 4'd9) ? 4'd0 : mant[4*k +: 4] + 4'd1;
      end
    end
    // all nines: wraps to a leading one
    if (carry[DIGITS]) begin
      mant_inc = '0;
      mant_inc[4*DIGITS-1 -: 4] = 4'd1;
    end
    overflow = carry[DIGITS];
  end

endmodule
`default_nettype wire

@@ design/decimal_text_to_bcd_real_top.sv @@
// Top level: decimal text to packed BCD calculator real converter.
//
//   channel  dir  words                                    handshake
//   chars    in   char_code, is_last, complex_part         valid/ready
//   result   out  flag_byte, exponent_byte, mantissa_bcd,  valid/ready
//                 exponent_warning
//
// One character word is taken per cycle while chars.ready is high; the parse
// state updates in that same cycle. A word with is_last set loads the result
// register on its edge, so the result shows in the cycle after the last character.
// Sustained rate is one word per cycle while the sink takes each result.
// rst is synchronous and clears the parse state and the result valid flag.
// chars.ready drops only while a result waits in the output register and
// the sink is not taking it.
`default_nettype none
module decimal_text_to_bcd_real_top #(
  parameter int DIGITS = dtb_pkg::DIGITS
) (
  input wire logic    clk,
  input wire logic    rst,
  dtb_in_if.sink      chars,
  dtb_out_if.source   result
);

  localparam int MW = 4 * DIGITS;
  localparam int CW = $clog2(DIGITS + 2);
  localparam int EW = dtb_pkg::EXP_MAG_W;

  // parse state
  logic [MW-1:0] mant, mant_next;
  logic [7:0]    exp_sum, exp_sum_next;
  logic          neg, neg_next;
  logic          in_exp, in_exp_next;
  logic          point, point_next;
  logic          lead, lead_next;
  logic [CW-1:0] sig_cnt, sig_cnt_next;
  logic [7:0]    int_cnt, int_cnt_next;
  logic [EW-1:0] wexp, wexp_next;
  logic          wexp_neg, wexp_neg_next;

  logic          accept;
  logic [7:0]    c;
  logic          is_digit;
  logic [3:0]    d;
  logic [EW+3:0] wexp_acc;
  logic [MW-1:0] mant_inc;
  logic          inc_ovf;
  logic [7:0]    wexp_term;
  logic [7:0]    exp_out;

  assign chars.ready = !result.valid || result.ready;
  assign accept      = chars.valid && chars.ready;

  assign c        = chars.char_code;
  assign is_digit = (c >= dtb_pkg::CH_ZERO) && (c <= dtb_pkg::CH_NINE);
  assign d        = c[3:0];

  // written exponent: w*10 + d, saturating
  assign wexp_acc = {1'b0, wexp, 3'b000} + {3'b000, wexp, 1'b0} + {{EW{1'b0}}, d};

  dtb_bcd_inc #(.DIGITS(DIGITS)) u_inc (
    .mant     (mant),
    .mant_inc (mant_inc),
    .overflow (inc_ovf)
  );

  always_comb begin
    mant_next     = mant;
    exp_sum_next  = exp_sum;
    neg_next      = neg;
    in_exp_next   = in_exp;
    point_next    = point;
    lead_next     = lead;
    sig_cnt_next  = sig_cnt;
    int_cnt_next  = int_cnt;
    wexp_next     = wexp;
    wexp_neg_next = wexp_neg;

    if (in_exp) begin
      // exponent part: sign only before a nonzero digit; '.', 'e' ignored
      if (c == dtb_pkg::CH_MINUS) begin
        if (wexp == '0) begin
          wexp_neg_next = 1'b1;
        end
      end else if (is_digit) begin
        wexp_next = (|wexp_acc[EW+3:EW]) ? dtb_pkg::EXP_MAG_MAX : wexp_acc[EW-1:0];
      end
    end else begin
      priority if (c == dtb_pkg::CH_MINUS) begin
        neg_next = 1'b1;
      end else if (c == dtb_pkg::CH_POINT) begin
        point_next = 1'b1;
      end else if (c == dtb_pkg::CH_E_LO || c == dtb_pkg::CH_E_UP) begin
        in_exp_next = 1'b1;
      end else if (is_digit) begin
        if (!point) begin
          int_cnt_next = int_cnt + 8'd1;
        end
        if (d == 4'd0 && lead) begin
          // leading zero shifts the exponent down
          exp_sum_next = exp_sum - 8'd1;
        end else begin
          lead_next = 1'b0;
          if (sig_cnt < CW'(DIGITS)) begin
            for (int k = 0; k < DIGITS; k++) begin
              if (sig_cnt == CW'(DIGITS - 1 - k)) begin
                mant_next[4*k +: 4] = mant[4*k +: 4] | d;
              end
            end
            sig_cnt_next = sig_cnt + CW'(1);
          end else if (sig_cnt == CW'(DIGITS)) begin
            // rounding digit: half away from zero
            if (d >= dtb_pkg::ROUND_HALF) begin
              mant_next = mant_inc;
              if (inc_ovf) begin
                exp_sum_next = exp_sum + 8'd1;
              end
            end
            sig_cnt_next = sig_cnt + CW'(1);
          end
        end
      end else begin
        // unknown character: no change
        neg_next = neg;
      end
    end
  end

  // final exponent from the state after this character
  assign wexp_term = wexp_neg_next ? (8'd0 - wexp_next[7:0]) : wexp_next[7:0];
  assign exp_out   = exp_sum_next + int_cnt_next + 8'hFF + wexp_term;

  // parse state; a last character returns it to the reset values
  always_ff @(posedge clk) begin
    if (rst || (accept && chars.is_last)) begin
      mant     <= '0;
      exp_sum  <= dtb_pkg::EXP_BIAS;
      neg      <= 1'b0;
      in_exp   <= 1'b0;
      point    <= 1'b0;
      lead     <= 1'b1;
      sig_cnt  <= '0;
      int_cnt  <= '0;
      wexp     <= '0;
      wexp_neg <= 1'b0;
    end else if (accept) begin
      mant     <= mant_next;
      exp_sum  <= exp_sum_next;
      neg      <= neg_next;
      in_exp   <= in_exp_next;
      point    <= point_next;
      lead     <= lead_next;
      sig_cnt  <= sig_cnt_next;
      int_cnt  <= int_cnt_next;
      wexp     <= wexp_next;
      wexp_neg <= wexp_neg_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (accept && chars.is_last) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && chars.is_last) begin
      result.flag_byte        <= (neg_next ? dtb_pkg::SIGN_FLAG : 8'h00)
                               | (chars.complex_part ? dtb_pkg::COMPLEX_FLAG : 8'h00);
      result.exponent_byte    <= exp_out;
      result.mantissa_bcd     <= mant_next;
      result.exponent_warning <= (wexp_next > dtb_pkg::EXP_WARN_LIMIT);
    end
  end

endmodule
`default_nettype wire

@@ design/dtb_checker.sv @@
// Checker: port-level assertions on the converter top, bound in below.
`default_nettype none
`include "assert_macros.svh"
module dtb_checker #(
  parameter int DIGITS = dtb_pkg::DIGITS
) (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                in_last,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [4*DIGITS-1:0] out_mant,
  input wire logic [7:0]          out_exp
);

  `DTB_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `DTB_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_mant) && $stable(out_exp), "result changed while stalled")
  `DTB_ASSERT(a_last_gives_result, in_valid && in_ready && in_last |=> out_valid, "last character gave no result")
  `DTB_ASSERT(a_stall_blocks_input, out_valid && !out_ready |-> !in_ready, "input taken over a waiting result")
  `DTB_ASSERT_RST(a_reset_clears, rst |=> !out_valid, "result valid after reset")

endmodule

bind decimal_text_to_bcd_real_top dtb_checker #(.DIGITS(DIGITS)) u_dtb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (chars.valid),
  .in_ready  (chars.ready),
  .in_last   (chars.is_last),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_mant  (result.mantissa_bcd),
  .out_exp   (result.exponent_byte)
);
`default_nettype wire

@@ tb/dtb_real_checker.sv @@
// Checker: predicts each BCD real from the accepted character words and compares results.
module dtb_real_checker (
  input  logic clk,
  input  logic rst,
  dtb_in_if    chars,
  dtb_out_if   result,
  output int   mismatch_count,
  output int   outstanding,
  output int   results_checked,
  output int   warnings_seen,
  output int   carries_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import dtb_pkg::*;

  typedef struct packed {
    logic [7:0]          flag_byte;
    logic [7:0]          exponent_byte;
    logic [4*DIGITS-1:0] mantissa_bcd;
    logic                exponent_warning;
  } bcd_real_t;

  bcd_real_t pending_reals[$];

  // parse state
  logic [4*DIGITS-1:0] mant_acc;
  logic [7:0]          exp_acc;     // bias, leading-zero and carry part
  logic [7:0]          int_digits;  // digits before the point, mod 256
  bit                  neg_seen, in_exp, point_seen, lead_zeros, exp_neg;
  int                  sig_digits;
  int                  exp_mag;     // saturating written exponent

  bcd_real_t got, want;
  logic [3:0] digit;
  logic [7:0] exp_add;
  bit         carry;

  task automatic clear_parse();
    mant_acc   = '0;
    exp_acc    = EXP_BIAS;
    int_digits = '0;
    neg_seen   = 1'b0;
    in_exp     = 1'b0;
    point_seen = 1'b0;
    lead_zeros = 1'b1;
    exp_neg    = 1'b0;
    sig_digits = 0;
    exp_mag    = 0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_parse();
      pending_reals.delete();
    end else begin
      // results leave before the word on this edge can add one
      if (result.valid && result.ready) begin
        got = '{result.flag_byte, result.exponent_byte, result.mantissa_bcd,
                result.exponent_warning};
        if (pending_reals.size() == 0) begin
          $display("%0t unexpected result: expected none, got %h", $time, got);
          mismatch_count++;
        end else begin
          want = pending_reals.pop_front();
          results_checked++;
          if (got.flag_byte !== want.flag_byte)
            $display("%0t flag_byte: expected %h, got %h", $time,
                     want.flag_byte, got.flag_byte);
          if (got.exponent_byte !== want.exponent_byte)
            $display("%0t exponent_byte: expected %h, got %h", $time,
                     want.exponent_byte, got.exponent_byte);
          if (got.mantissa_bcd !== want.mantissa_bcd)
            $display("%0t mantissa_bcd: expected %h, got %h", $time,
                     want.mantissa_bcd, got.mantissa_bcd);
          if (got.exponent_warning !== want.exponent_warning)
            $display("%0t exponent_warning: expected %b, got %b", $time,
                     want.exponent_warning, got.exponent_warning);
          if (got !== want)
            mismatch_count++;
        end
      end

      if (chars.valid && chars.ready) begin
        digit = 4'(chars.char_code - CH_ZERO);
        if (in_exp) begin
          if (chars.char_code == CH_MINUS) begin
            if (exp_mag == 0)
              exp_neg = 1'b1;
          end else if (chars.char_code >= CH_ZERO && chars.char_code <= CH_NINE) begin
            exp_mag = exp_mag * 10 + digit;
            if (exp_mag > EXP_MAG_MAX)
              exp_mag = EXP_MAG_MAX;
          end
        end else if (chars.char_code == CH_MINUS) begin
          neg_seen = 1'b1;
        end else if (chars.char_code == CH_POINT) begin
          point_seen = 1'b1;
        end else if (chars.char_code == CH_E_UP || chars.char_code == CH_E_LO) begin
          in_exp = 1'b1;
        end else if (chars.char_code >= CH_ZERO && chars.char_code <= CH_NINE) begin
          if (!point_seen)
            int_digits++;
          if (digit == 0 && lead_zeros) begin
            exp_acc--;
          end else begin
            lead_zeros = 1'b0;
            if (sig_digits < DIGITS) begin
              mant_acc[4*(DIGITS-1-sig_digits) +: 4] = digit;
              sig_digits++;
            end else if (sig_digits == DIGITS) begin
              // rounding digit: half away from zero, full BCD ripple
              if (digit >= ROUND_HALF) begin
                carry = 1'b1;
                for (int k = 0; k < DIGITS; k++) begin
                  if (carry) begin
                    if (mant_acc[4*k +: 4] < 4'd9) begin
                      mant_acc[4*k +: 4]++;
                      carry = 1'b0;
                    end else begin
                      mant_acc[4*k +: 4] = 4'd0;
                    end
                  end
                end
                if (carry) begin
                  mant_acc[4*DIGITS-1 -: 4] = 4'd1;
                  exp_acc++;
                  carries_seen++;
                end
              end
              sig_digits++;
            end
          end
        end

        if (chars.is_last) begin
          exp_add = exp_neg ? 8'(-exp_mag) : 8'(exp_mag);
          want.flag_byte        = (neg_seen ? SIGN_FLAG : 8'h00) |
                                  (chars.complex_part ? COMPLEX_FLAG : 8'h00);
          want.exponent_byte    = exp_acc + int_digits - 8'd1 + exp_add;
          want.mantissa_bcd     = mant_acc;
          want.exponent_warning = (exp_mag > EXP_WARN_LIMIT);
          if (want.exponent_warning)
            warnings_seen++;
          pending_reals.push_back(want);
          clear_parse();
        end
      end
    end
    outstanding = pending_reals.size();
  end

endmodule

@@ tb/tb_decimal_text_to_bcd_real_top.sv @@
// Testbench top: character stimulus, output back-pressure and verdict for the BCD real block.
module tb_decimal_text_to_bcd_real_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dtb_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int WORDS_PER_PHASE = 330;     // four phases plus directed ~ 1650 words
  localparam logic [7:0] CH_PLUS = 8'h2B;   // not a known character: must be ignored

  logic clk;
  logic rst;

  dtb_in_if  chars_if ();
  dtb_out_if result_if ();

  int mismatch_count, outstanding, results_checked, warnings_seen, carries_seen;
  int sender_idle_pct, sink_stall_pct;
  int words_sent, texts_sent, cycle_count, drain_wait;

  logic [7:0] text_q[$];   // characters of the number being sent

  // Short directed texts:
  //   unknown lone character  -> empty number, exponent 0x7F
  //   lone zero               -> all-zero number
  //   doubled minus, second point
  //   zero after the point, minus/point/'e' inside the exponent part
  //   exponent beyond 99      -> warning
  //   leading plus            -> ignored
  string directed_texts[6] = '{"?", "0", "--1..5", ".0e-1-.e9", "7E999", "+3"};

  decimal_text_to_bcd_real_top dut (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_if),
    .result (result_if)
  );

  dtb_real_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .chars           (chars_if),
    .result          (result_if),
    .mismatch_count  (mismatch_count),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .warnings_seen   (warnings_seen),
    .carries_seen    (carries_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result sink: drops ready at the phase's stall rate, every cycle afresh.
  always @(posedge clk) begin
    result_if.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Sends text_q, is_last on its final word. Valid is only lowered in an idle
  // gap, so back-to-back texts never see two assignments in one time step.
  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) begin
      while ($urandom_range(99) < sender_idle_pct) begin
        chars_if.valid <= 1'b0;
        @(posedge clk);
      end
      chars_if.valid        <= 1'b1;
      chars_if.char_code    <= text_q[i];
      chars_if.is_last      <= (i == text_q.size() - 1);
      chars_if.complex_part <= 1'($urandom_range(1));  // only matters on the last word
      do @(posedge clk); while (!chars_if.ready);
      words_sent++;
    end
    texts_sent++;
  endtask

  // Builds one random number text in text_q. Mostly well formed: sign, leading
  // zeros, digits, an optional point, then an optional signed exponent. A few
  // are pure noise, and stray characters are sprinkled through the rest.
  task automatic build_number();
    int  lead, ndig, pt_at, nexp, pick;
    bit  nines;
    text_q.delete();
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(255)));
      return;
    end

    if ($urandom_range(3) == 0) text_q.push_back(CH_MINUS);
    if ($urandom_range(19) == 0) text_q.push_back(CH_MINUS);

    // all nines past the rounding digit forces the carry out of the top digit
    nines = ($urandom_range(9) == 0);
    lead  = nines ? 0 : (($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(3));
    ndig  = nines ? $urandom_range(15, 17)
                  : (($urandom_range(99) < 70) ? $urandom_range(8) : $urandom_range(13, 18));
    pt_at = $urandom_range(1) ? $urandom_range(lead + ndig) : -1;
    for (int i = 0; i <= lead + ndig; i++) begin
      if (i == pt_at) begin
        text_q.push_back(CH_POINT);
        if ($urandom_range(19) == 0) text_q.push_back(CH_POINT);
      end
      if ($urandom_range(39) == 0) text_q.push_back(8'($urandom_range(255)));
      if (i < lead)
        text_q.push_back(CH_ZERO);
      else if (i < lead + ndig)
        text_q.push_back(nines ? CH_NINE : 8'(CH_ZERO + $urandom_range(9)));
    end

    if ($urandom_range(99) < 40) begin
      text_q.push_back($urandom_range(1) ? CH_E_UP : CH_E_LO);
      pick = $urandom_range(99);
      if (pick < 35)
        text_q.push_back(CH_MINUS);
      else if (pick < 45)
        text_q.push_back(CH_PLUS);
      // long exponents run into the saturation of the magnitude
      nexp = ($urandom_range(99) < 85) ? $urandom_range(1, 3) : $urandom_range(4, 6);
      for (int i = 0; i < nexp; i++) begin
        if ($urandom_range(99) < 5) begin
          pick = $urandom_range(2);
          text_q.push_back(pick == 0 ? CH_MINUS : (pick == 1 ? CH_POINT : CH_E_LO));
        end
        text_q.push_back(8'(CH_ZERO + $urandom_range(9)));
      end
    end

    if (text_q.size() == 0) text_q.push_back(CH_ZERO);
    if ($urandom_range(99) < 4) text_q.push_back(8'($urandom_range(255)));
  endtask

  initial begin
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    rst                   <= 1'b1;
    chars_if.valid        <= 1'b0;
    chars_if.char_code    <= '0;
    chars_if.is_last      <= 1'b0;
    chars_if.complex_part <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_texts[t]) begin
      text_q.delete();
      for (int i = 0; i < directed_texts[t].len(); i++)
        text_q.push_back(directed_texts[t][i]);
      send_text();
    end

    // Integer part longer than 256 digits: the digit count wraps in the byte.
    text_q.delete();
    text_q.push_back(8'(CH_ZERO + 1));
    repeat (299) text_q.push_back(CH_ZERO);
    send_text();

    // Phases: free flow, sender gaps, sink stalls, both at once.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin sender_idle_pct = 63; sink_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  sink_stall_pct = 63; end
        default: begin sender_idle_pct = 28; sink_stall_pct = 28; end
      endcase
      // hold off until the block has handed over every pending result
      chars_if.valid <= 1'b0;
      do @(posedge clk); while (outstanding != 0);
      for (int n = words_sent + WORDS_PER_PHASE; words_sent < n; ) begin
        build_number();
        send_text();
      end
    end

    // Drain: wait on the results, bounded, then wait on for stragglers.
    chars_if.valid <= 1'b0;
    sink_stall_pct = 0;
    drain_wait = 0;
    do begin
      @(posedge clk);
      drain_wait++;
    end while (outstanding != 0 && drain_wait < 1000);
    repeat (4) @(posedge clk);

    $display("%0d character words in %0d texts; %0d reals checked, %0d with exponent warning,",
             words_sent, texts_sent, results_checked, warnings_seen);
    $display("%0d all-nines rounding carries; %0d mismatches, %0d reals never seen",
             carries_seen, mismatch_count, outstanding);
    if (mismatch_count == 0 && outstanding == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/dtb_pkg.sv
design/dtb_if.sv
design/dtb_bcd_inc.sv
design/decimal_text_to_bcd_real_top.sv
design/dtb_checker.sv
tb/dtb_real_checker.sv
tb/tb_decimal_text_to_bcd_real_top.sv
